// File: rtl/mseu_pkg.sv
// ----------------------------------------------------------------------------
// mseu_pkg
// Shared types and constants of the integer subset execute unit: operation
// codes, data memory size and the packed item and result words.
// ----------------------------------------------------------------------------
package mseu_pkg;

  localparam int DATA_WORDS = 1024;
  localparam int IDX_W      = $clog2(DATA_WORDS);
  localparam int RF_DEPTH   = 32;

  localparam logic [31:0] J_REGION_MASK = 32'hF000_0000;

  localparam logic [4:0] MODE_J    = 5'd0;
  localparam logic [4:0] MODE_JR   = 5'd1;
  localparam logic [4:0] MODE_BEQ  = 5'd2;
  localparam logic [4:0] MODE_BLTZ = 5'd3;
  localparam logic [4:0] MODE_BGTZ = 5'd4;
  localparam logic [4:0] MODE_SW   = 5'd5;
  localparam logic [4:0] MODE_LW   = 5'd6;
  localparam logic [4:0] MODE_SLL  = 5'd7;
  localparam logic [4:0] MODE_SRL  = 5'd8;
  localparam logic [4:0] MODE_SRA  = 5'd9;
  localparam logic [4:0] MODE_NOP  = 5'd10;
  localparam logic [4:0] MODE_BRK  = 5'd11;
  localparam logic [4:0] MODE_ADD  = 5'd12;
  localparam logic [4:0] MODE_SUB  = 5'd13;
  localparam logic [4:0] MODE_MUL  = 5'd14;
  localparam logic [4:0] MODE_AND  = 5'd15;
  localparam logic [4:0] MODE_OR   = 5'd16;
  localparam logic [4:0] MODE_XOR  = 5'd17;
  localparam logic [4:0] MODE_NOR  = 5'd18;
  localparam logic [4:0] MODE_SLT  = 5'd19;
  localparam logic [4:0] MODE_ADDI = 5'd20;
  localparam logic [4:0] MODE_ANDI = 5'd21;
  localparam logic [4:0] MODE_ORI  = 5'd22;
  localparam logic [4:0] MODE_XORI = 5'd23;

  typedef struct packed {
    logic [4:0]         mode;
    logic [4:0]         src_reg;
    logic [4:0]         second_reg;
    logic [4:0]         dest_field;
    logic [4:0]         shift_amount;
    logic signed [15:0] immediate;
    logic [25:0]        jump_index;
    logic [31:0]        current_pc;
  } exec_in_t;

  typedef struct packed {
    logic               jump_taken;
    logic [31:0]        jump_target;
    logic               reg_write;
    logic [4:0]         dest_reg;
    logic signed [31:0] dest_value;
    logic               mem_write;
    logic [31:0]        mem_address;
    logic signed [31:0] store_value;
    logic               address_fault;
  } exec_out_t;

endpackage

// File: rtl/mips_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes one decoded instruction per word against a 32-entry register
// file and a word data memory, and reports the effects as one result word.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall, payload item (one instruction).
//   result channel : result_valid / result_stall, payload result.
//   cfg channel    : cfg_valid / cfg_ready / cfg_data writes data_base, always ready;
//                    user must write only while the unit is idle; not enforced.
// Timing: the cycle after acceptance the operands (read from the register
//   file at the accepting edge, with forwarding from the result stage) pass
//   the ALU, branch and address logic; the edge on which the result stage
//   is open loads the result register and does the data memory access.
//   One word is taken every cycle while the result channel does not stall;
//   the throughput is set by the single ALU pass, the registered register
//   file read and the one data memory port. The register file write of each result
//   lands in the cycle after the result register loads and is forwarded meanwhile.
// Reset: a clearing pass over the larger of the data memory and the register
//   file zeros both; item_stall stays high during it.
// Stall: when result_stall holds a valid result, the result stays put and
//   item_stall rises once the operand stage is also full.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  mseu_pkg::exec_in_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output mseu_pkg::exec_out_t  result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);

  localparam int IDX_W     = mseu_pkg::IDX_W;
  localparam int CLR_WORDS = (mseu_pkg::DATA_WORDS > mseu_pkg::RF_DEPTH) ?
                             mseu_pkg::DATA_WORDS : mseu_pkg::RF_DEPTH;
  localparam int CLR_W     = $clog2(CLR_WORDS);
  localparam logic [CLR_W:0] RF_LIMIT  = (CLR_W+1)'(mseu_pkg::RF_DEPTH);
  localparam logic [CLR_W:0] MEM_LIMIT = (CLR_W+1)'(mseu_pkg::DATA_WORDS);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_WORDS - 1);
  localparam logic [29:0] WORD_LIMIT = 30'(mseu_pkg::DATA_WORDS);

  logic [31:0] rf [mseu_pkg::RF_DEPTH];
  logic [31:0] dm [mseu_pkg::DATA_WORDS];

  logic [31:0] data_base;

  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;

  // operand stage
  logic               s1_valid;
  mseu_pkg::exec_in_t s1;
  logic [31:0]        a_q;
  logic [31:0]        b_q;

  // result stage
  logic        s2_jt;
  logic [31:0] s2_target;
  logic        s2_rw;
  logic [4:0]  s2_dreg;
  logic [31:0] s2_dval;
  logic        s2_mw;
  logic [31:0] s2_maddr;
  logic [31:0] s2_sval;
  logic        s2_fault;
  logic        s2_load;
  logic        s2_fresh;
  logic [31:0] mem_q;

  logic        accept;
  logic        s2_open;
  logic        s1_adv;
  logic [31:0] s2_value;
  logic        wb_en;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  // ALU stage signals
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] br_target;
  logic [31:0] maddr;
  logic [31:0] off;
  logic        map_bad;
  logic [IDX_W-1:0] widx;
  logic        jt;
  logic [31:0] target;
  logic        rw;
  logic [4:0]  dreg;
  logic [31:0] dval;
  logic        mw;
  logic        ld;
  logic [31:0] sval;
  logic        fault;
  logic [31:0] maddr_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      data_base <= cfg_data;
    end
  end

  assign s2_open    = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && s2_open;
  assign item_stall = clearing || (s1_valid && !s2_open);
  assign accept     = item_valid && !item_stall;

  assign s2_value = s2_load ? mem_q : s2_dval;
  assign wb_en    = s2_fresh && s2_rw;

  always_comb begin
    if (clearing) begin
      rf_we = ({1'b0, clr_cnt} < RF_LIMIT);
      rf_wa = clr_cnt[4:0];
      rf_wd = '0;
    end else begin
      rf_we = wb_en;
      rf_wa = s2_dreg;
      rf_wd = s2_value;
    end
  end

  // register file: one write port, two registered reads with write-through
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (accept) begin
      a_q <= (wb_en && s2_dreg == item.src_reg) ? s2_value : rf[item.src_reg];
      b_q <= (wb_en && s2_dreg == item.second_reg) ? s2_value : rf[item.second_reg];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= item;
    end
  end

  // operands, with the result stage forwarded
  assign a = (s2_rw && s2_dreg == s1.src_reg) ? s2_value : a_q;
  assign b = (s2_rw && s2_dreg == s1.second_reg) ? s2_value : b_q;

  assign simm      = {{16{s1.immediate[15]}}, s1.immediate};
  assign zimm      = {16'd0, s1.immediate};
  assign br_target = s1.current_pc + {simm[29:0], 2'b00};
  assign maddr     = a + simm;
  assign off       = maddr - data_base;
  assign map_bad   = (off[1:0] != 2'b00) || (off[31:2] >= WORD_LIMIT);
  assign widx      = off[IDX_W+1:2];

  always_comb begin
    jt        = 1'b0;
    target    = '0;
    rw        = 1'b0;
    dreg      = '0;
    dval      = '0;
    mw        = 1'b0;
    ld        = 1'b0;
    sval      = '0;
    fault     = 1'b0;
    maddr_out = '0;
    case (s1.mode)
      mseu_pkg::MODE_J: begin
        jt     = 1'b1;
        target = (s1.current_pc & mseu_pkg::J_REGION_MASK) | {4'd0, s1.jump_index, 2'b00};
      end
      mseu_pkg::MODE_JR: begin
        jt     = 1'b1;
        target = a;
      end
      mseu_pkg::MODE_BEQ: begin
        if (a == b) begin
          jt     = 1'b1;
          target = br_target;
        end
      end
      mseu_pkg::MODE_BLTZ: begin
        if (a[31]) begin
          jt     = 1'b1;
          target = br_target;
        end
      end
      mseu_pkg::MODE_BGTZ: begin
        if (!a[31] && a != 32'd0) begin
          jt     = 1'b1;
          target = br_target;
        end
      end
      mseu_pkg::MODE_SW: begin
        maddr_out = maddr;
        sval      = b;
        mw        = !map_bad;
        fault     = map_bad;
      end
      mseu_pkg::MODE_LW: begin
        maddr_out = maddr;
        fault     = map_bad;
        rw        = !map_bad;
        ld        = !map_bad;
        dreg      = map_bad ? 5'd0 : s1.second_reg;
      end
      mseu_pkg::MODE_SLL: begin
        rw = 1'b1; dreg = s1.dest_field; dval = b << s1.shift_amount;
      end
      mseu_pkg::MODE_SRL: begin
        rw = 1'b1; dreg = s1.dest_field; dval = b >> s1.shift_amount;
      end
      mseu_pkg::MODE_SRA: begin
        rw = 1'b1; dreg = s1.dest_field; dval = $signed(b) >>> s1.shift_amount;
      end
      mseu_pkg::MODE_ADD: begin
        rw = 1'b1; dreg = s1.dest_field; dval = a + b;
      end
      mseu_pkg::MODE_SUB: begin
        rw = 1'b1; dreg = s1.dest_field; dval = a - b;
      end
      mseu_pkg::MODE_MUL: begin
        rw = 1'b1; dreg = s1.dest_field; dval = a * b;
      end
      mseu_pkg::MODE_AND: begin
        rw = 1'b1; dreg = s1.dest_field; dval = a & b;
      end
      mseu_pkg::MODE_OR: begin
        rw = 1'b1; dreg = s1.dest_field; dval = a | b;
      end
      mseu_pkg::MODE_XOR: begin
        rw = 1'b1; dreg = s1.dest_field; dval = a ^ b;
      end
      mseu_pkg::MODE_NOR: begin
        rw = 1'b1; dreg = s1.dest_field; dval = ~(a | b);
      end
      mseu_pkg::MODE_SLT: begin
        rw = 1'b1; dreg = s1.dest_field;
        dval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      end
      mseu_pkg::MODE_ADDI: begin
        rw = 1'b1; dreg = s1.second_reg; dval = a + simm;
      end
      mseu_pkg::MODE_ANDI: begin
        rw = 1'b1; dreg = s1.second_reg; dval = a & zimm;
      end
      mseu_pkg::MODE_ORI: begin
        rw = 1'b1; dreg = s1.second_reg; dval = a | zimm;
      end
      mseu_pkg::MODE_XORI: begin
        rw = 1'b1; dreg = s1.second_reg; dval = a ^ zimm;
      end
      default: begin
        // NOP, BRK and unused codes change nothing
      end
    endcase
  end

  // data memory: clear pass or store writes, load reads as the word moves on
  always_ff @(posedge clk) begin
    if (clearing) begin
      if ({1'b0, clr_cnt} < MEM_LIMIT) begin
        dm[clr_cnt[IDX_W-1:0]] <= '0;
      end
    end else if (s1_adv && mw) begin
      dm[widx] <= b;
    end
    if (s1_adv && ld) begin
      mem_q <= dm[widx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      s2_fresh     <= 1'b0;
      s2_rw        <= 1'b0;
    end else begin
      s2_fresh <= s1_adv;
      if (s1_adv) begin
        result_valid <= 1'b1;
        s2_rw        <= rw;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_jt     <= jt;
      s2_target <= target;
      s2_dreg   <= dreg;
      s2_dval   <= dval;
      s2_mw     <= mw;
      s2_maddr  <= maddr_out;
      s2_sval   <= sval;
      s2_fault  <= fault;
      s2_load   <= ld;
    end
  end

  always_comb begin
    result.jump_taken    = s2_jt;
    result.jump_target   = s2_target;
    result.reg_write     = s2_rw;
    result.dest_reg      = s2_dreg;
    result.dest_value    = s2_value;
    result.mem_write     = s2_mw;
    result.mem_address   = s2_maddr;
    result.store_value   = s2_sval;
    result.address_fault = s2_fault;
  end

endmodule
